### design/prbt_pkg.sv
// Shared types and constants for the page/row bitmap transposer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package prbt_pkg;

    localparam int ADDR_W = 13;
    localparam int CMD_AW = 10;

    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_DIRECTION    = 2'd2;

    localparam logic DIR_PAGE_TO_ROW = 1'b0;
    localparam logic DIR_ROW_TO_PAGE = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } in_t;

    typedef struct packed {
        logic [7:0]        out_byte;
        logic [ADDR_W-1:0] out_address;
        logic              run_last;
        logic              frame_last;
    } out_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] index;
        logic [8:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic [7:0]        data_byte;
        logic [CMD_AW-1:0] waddr;
        logic              tile;
        logic              dir;
        logic [2:0]        rd_last;
        logic [CMD_AW-1:0] rd_start;
        logic [CMD_AW-1:0] rd_step;
        logic [2:0]        out_last;
        logic [ADDR_W-1:0] addr_base;
        logic [ADDR_W-1:0] addr_step;
        logic              final_tile;
    } cmd_t;

endpackage

`default_nettype wire

### design/prbt_front.sv
// Front end: configuration registers, position counters, item classification.
// Depends on prbt_pkg; produces one cmd_t per accepted item.
`timescale 1ns / 1ps
`default_nettype none

module prbt_front #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire prbt_pkg::cfg_wr_t cfg,
    input  wire logic              in_valid,
    input  wire prbt_pkg::in_t     in_data,
    input  wire logic              q_full,
    output logic                   push,
    output prbt_pkg::cmd_t         cmd
);
    import prbt_pkg::*;

    localparam int RB_MAX      = (MAX_WIDTH + 7) / 8;
    localparam int STORE_DEPTH = 8 * RB_MAX;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam int CW          = $clog2(MAX_WIDTH + 1);
    localparam int RW          = $clog2(MAX_HEIGHT + 1);

    logic [8:0]    fw_reg;
    logic [8:0]    fh_reg;
    logic          dir_reg;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;

    logic [CW-1:0]     w;
    logic [RW-1:0]     h;
    logic [CW:0]       w_pad;
    logic [RW:0]       h_pad;
    logic [CW-1:0]     rb;
    logic [RW-1:0]     pages;
    logic [CW-1:0]     c0;
    logic [CW-1:0]     c;
    logic [CW-1:0]     lim_c;
    logic [RW-1:0]     r0;
    logic [RW-1:0]     r;
    logic [RW-1:0]     lim_r;
    logic [RW+2:0]     y0;
    logic [RW+2:0]     hrem;
    logic [CW+2:0]     wrem;
    logic [ADDR_W-1:0] mul_a;
    logic [ADDR_W-1:0] mul_b;
    logic [ADDR_W-1:0] mul_p;
    logic [AW-1:0]     waddr1;

    assign push = in_valid && !q_full;

    always_comb
    begin
        if (fw_reg == 9'd0)
            w = CW'(1);
        else if (32'(fw_reg) > 32'(MAX_WIDTH))
            w = CW'(MAX_WIDTH);
        else
            w = CW'(fw_reg);
        if (fh_reg == 9'd0)
            h = RW'(1);
        else if (32'(fh_reg) > 32'(MAX_HEIGHT))
            h = RW'(MAX_HEIGHT);
        else
            h = RW'(fh_reg);

        w_pad = {1'b0, w} + (CW + 1)'(7);
        h_pad = {1'b0, h} + (RW + 1)'(7);
        rb    = CW'(w_pad >> 3);
        pages = RW'(h_pad >> 3);

        c0 = in_data.frame_start ? '0 : col_reg;
        r0 = in_data.frame_start ? '0 : row_reg;
        lim_c = (dir_reg == DIR_ROW_TO_PAGE) ? rb : w;
        lim_r = (dir_reg == DIR_ROW_TO_PAGE) ? h : pages;
        if (c0 >= lim_c || r0 >= lim_r)
        begin
            c = '0;
            r = '0;
        end
        else
        begin
            c = c0;
            r = r0;
        end

        y0   = {r, 3'b000};
        hrem = (RW + 3)'(h) - y0;
        wrem = (CW + 3)'(w) - {c, 3'b000};

        if (dir_reg == DIR_ROW_TO_PAGE)
        begin
            mul_a = ADDR_W'(r >> 3);
            mul_b = ADDR_W'(w);
        end
        else
        begin
            mul_a = ADDR_W'(y0);
            mul_b = ADDR_W'(rb);
        end
        mul_p  = mul_a * mul_b;
        waddr1 = AW'(r[2:0]) * AW'(rb) + AW'(c);

        cmd.data_byte = in_data.data_byte;
        cmd.dir       = dir_reg;
        if (dir_reg == DIR_ROW_TO_PAGE)
        begin
            cmd.waddr      = CMD_AW'(waddr1);
            cmd.tile       = (r[2:0] == 3'd7) || (r == h - RW'(1));
            cmd.rd_last    = r[2:0];
            cmd.rd_start   = CMD_AW'(c);
            cmd.rd_step    = CMD_AW'(rb);
            cmd.out_last   = (wrem >= (CW + 3)'(8)) ? 3'd7 : 3'(wrem - (CW + 3)'(1));
            cmd.addr_base  = ADDR_W'({c, 3'b000}) + mul_p;
            cmd.addr_step  = ADDR_W'(1);
            cmd.final_tile = (r == h - RW'(1)) && (c == rb - CW'(1));
        end
        else
        begin
            cmd.waddr      = CMD_AW'(c[2:0]);
            cmd.tile       = (c[2:0] == 3'd7) || (c == w - CW'(1));
            cmd.rd_last    = c[2:0];
            cmd.rd_start   = '0;
            cmd.rd_step    = CMD_AW'(1);
            cmd.out_last   = (hrem >= (RW + 3)'(8)) ? 3'd7 : 3'(hrem - (RW + 3)'(1));
            cmd.addr_base  = ADDR_W'(c >> 3) + mul_p;
            cmd.addr_step  = ADDR_W'(rb);
            cmd.final_tile = (r == pages - RW'(1)) && (c == w - CW'(1));
        end

        col_next = c + CW'(1);
        row_next = r;
        if (col_next >= lim_c)
        begin
            col_next = '0;
            row_next = r + RW'(1);
            if (row_next >= lim_r)
                row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg  <= 9'd128;
            fh_reg  <= 9'd64;
            dir_reg <= DIR_PAGE_TO_ROW;
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_FRAME_WIDTH:  fw_reg  <= cfg.data;
                    CFG_FRAME_HEIGHT: fh_reg  <= cfg.data;
                    CFG_DIRECTION:    dir_reg <= cfg.data[0];
                    default:          ;
                endcase
            end
            if (push)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

endmodule

`default_nettype wire

### design/prbt_queue.sv
// Two-entry command queue between front end and back end.
// Depends on prbt_pkg for cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module prbt_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire prbt_pkg::cmd_t push_cmd,
    input  wire logic           pop,
    output logic                full,
    output logic                q_valid,
    output prbt_pkg::cmd_t      q_cmd
);
    import prbt_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_cmd   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

`default_nettype wire

### design/prbt_back.sv
// Back end: line store, tile gather and transpose, result register.
// Depends on prbt_pkg; consumes cmd_t from the queue.
`timescale 1ns / 1ps
`default_nettype none

module prbt_back #(
    parameter int MAX_WIDTH = 256
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    input  wire prbt_pkg::cmd_t q_cmd,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_stall,
    output prbt_pkg::out_t      out_data
);
    import prbt_pkg::*;

    localparam int RB_MAX      = (MAX_WIDTH + 7) / 8;
    localparam int STORE_DEPTH = 8 * RB_MAX;
    localparam int AW          = $clog2(STORE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WAIT,
        S_EMIT
    } state_t;

    state_t            state_reg;
    logic [7:0]        store_mem [STORE_DEPTH];
    logic [7:0]        rd_data_reg;
    logic [AW-1:0]     rd_ptr_reg;
    logic [2:0]        rd_idx_reg;
    logic              cap_vld_reg;
    logic [2:0]        cap_idx_reg;
    logic [7:0]        tile_reg [8];
    logic [2:0]        k_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              dir_reg;
    logic [2:0]        rd_last_reg;
    logic [AW-1:0]     rd_step_reg;
    logic [2:0]        out_last_reg;
    logic [ADDR_W-1:0] addr_step_reg;
    logic              final_reg;
    logic              out_valid_reg;
    out_t              out_data_reg;

    logic       out_load;
    logic [7:0] ob;

    assign pop       = (state_reg == S_IDLE) && q_valid;
    assign out_load  = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        ob = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (dir_reg == DIR_ROW_TO_PAGE)
                ob[i] = tile_reg[i][7 - k_reg];
            else
                ob[7 - i] = tile_reg[i][k_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            store_mem[q_cmd.waddr[AW-1:0]] <= q_cmd.data_byte;
        rd_data_reg <= store_mem[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_ptr_reg    <= '0;
            rd_idx_reg    <= 3'd0;
            cap_vld_reg   <= 1'b0;
            cap_idx_reg   <= 3'd0;
            tile_reg      <= '{default: 8'h00};
            k_reg         <= 3'd0;
            addr_reg      <= '0;
            dir_reg       <= DIR_PAGE_TO_ROW;
            rd_last_reg   <= 3'd0;
            rd_step_reg   <= '0;
            out_last_reg  <= 3'd0;
            addr_step_reg <= '0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            cap_vld_reg <= 1'b0;
            if (cap_vld_reg)
                tile_reg[cap_idx_reg] <= rd_data_reg;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid && q_cmd.tile)
                    begin
                        tile_reg      <= '{default: 8'h00};
                        dir_reg       <= q_cmd.dir;
                        rd_last_reg   <= q_cmd.rd_last;
                        rd_step_reg   <= q_cmd.rd_step[AW-1:0];
                        rd_ptr_reg    <= q_cmd.rd_start[AW-1:0];
                        rd_idx_reg    <= 3'd0;
                        out_last_reg  <= q_cmd.out_last;
                        addr_reg      <= q_cmd.addr_base;
                        addr_step_reg <= q_cmd.addr_step;
                        final_reg     <= q_cmd.final_tile;
                        k_reg         <= 3'd0;
                        state_reg     <= S_READ;
                    end
                end
                S_READ:
                begin
                    cap_vld_reg <= 1'b1;
                    cap_idx_reg <= rd_idx_reg;
                    rd_ptr_reg  <= rd_ptr_reg + rd_step_reg;
                    rd_idx_reg  <= rd_idx_reg + 3'd1;
                    if (rd_idx_reg == rd_last_reg)
                        state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_load)
                    begin
                        out_valid_reg            <= 1'b1;
                        out_data_reg.out_byte    <= ob;
                        out_data_reg.out_address <= addr_reg;
                        out_data_reg.run_last    <= (k_reg == out_last_reg);
                        out_data_reg.frame_last  <= (k_reg == out_last_reg) && final_reg;
                        k_reg                    <= k_reg + 3'd1;
                        addr_reg                 <= addr_reg + addr_step_reg;
                        if (k_reg == out_last_reg)
                            state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### design/page_raster_bitmap_transposer.sv
// Top level of the page/row monochrome bitmap transposer.
// Depends on prbt_pkg, prbt_front, prbt_queue and prbt_back.
//
//  channel  handshake            payload
//  in       in_valid / in_stall  in_data   (prbt_pkg::in_t)
//  out      out_valid / out_stall out_data (prbt_pkg::out_t)
//  cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// An item without a finished tile is only written into the line store. An item that
// closes a tile is also written; then n store reads (n = bytes in the tile) in S_READ,
// a wait in S_WAIT for the registered read and m results (m up to 8) in S_EMIT.
// Reset clears counters and queue and sets default configuration; line store not cleared.
// out_stall holds the result register; in_stall rises while the two-entry queue is full.
`timescale 1ns / 1ps
`default_nettype none

module page_raster_bitmap_transposer #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire prbt_pkg::in_t  in_data,
    output logic                out_valid,
    input  wire logic           out_stall,
    output prbt_pkg::out_t      out_data,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [8:0]     cfg_data
);
    import prbt_pkg::*;

    cfg_wr_t cfg;
    cmd_t    push_cmd;
    cmd_t    q_cmd;
    logic    push;
    logic    pop;
    logic    q_full;
    logic    q_valid;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;

    always_comb
    begin
        cfg.valid = cfg_valid;
        cfg.index = cfg_index;
        cfg.data  = cfg_data;
    end

    prbt_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (in_valid),
        .in_data  (in_data),
        .q_full   (q_full),
        .push     (push),
        .cmd      (push_cmd)
    );

    prbt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (q_full),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    prbt_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
